// ===== sv/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types for the barometric sensor compensation block.
// ----------------------------------------------------------------------------
package bsc_pkg;

	// One raw sample pair
	typedef struct packed {
		logic [15:0] raw_temp;
		logic [23:0] raw_press;
	} bsc_in_t;

	// One compensated result
	typedef struct packed {
		logic signed [15:0] temperature;
		logic signed [31:0] pressure;
		logic               div_zero;
	} bsc_out_t;

	// Calibration coefficients and oversampling, unpacked from config registers
	typedef struct packed {
		logic [15:0] ac1;
		logic [15:0] ac2;
		logic [15:0] ac3;
		logic [15:0] ac4;
		logic [15:0] ac5;
		logic [15:0] ac6;
		logic [15:0] b1;
		logic [15:0] b2;
		logic [15:0] mc;
		logic [15:0] md;
		logic [1:0]  oss;
	} bsc_cal_t;

	// Queued work item: raw temperature and aligned pressure
	typedef struct packed {
		logic [15:0] ut;
		logic [23:0] up;
	} bsc_item_t;

	// Context carried down the compute pipeline
	typedef struct packed {
		logic [15:0] ut;
		logic [23:0] up;
		logic        dz;
		logic        neg;
		logic        dbl;
		logic [15:0] temp;
		logic [31:0] x1;
		logic [31:0] b5;
		logic [31:0] b3;
		logic [31:0] t0;
		logic [31:0] t1;
		logic [31:0] t2;
		logic [31:0] num;
		logic [31:0] den;
		logic [31:0] rem;
		logic [31:0] quo;
	} bsc_ctx_t;

	// Configuration register indexes
	localparam logic [2:0] REG_AC1_AC2 = 3'd0;
	localparam logic [2:0] REG_AC3_AC4 = 3'd1;
	localparam logic [2:0] REG_AC5_AC6 = 3'd2;
	localparam logic [2:0] REG_B1_B2   = 3'd3;
	localparam logic [2:0] REG_MC_MD   = 3'd4;
	localparam logic [2:0] REG_OSS     = 3'd5;

	localparam int QUEUE_DEPTH = 4;

endpackage

// ===== sv/bsc_front.sv =====
// ----------------------------------------------------------------------------
// bsc_front
// Accepts raw samples, aligns the pressure word to the oversampling setting
// and holds the items in a short queue for the compute pipeline.
// ----------------------------------------------------------------------------
module bsc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          oss,
	input  logic                sample_valid,
	output logic                sample_stall,
	input  bsc_pkg::bsc_in_t    sample,
	output logic                item_valid,
	input  logic                item_pop,
	output bsc_pkg::bsc_item_t  item
);

	localparam int PW = $clog2(bsc_pkg::QUEUE_DEPTH);

	bsc_pkg::bsc_item_t entry_q [bsc_pkg::QUEUE_DEPTH];
	logic [PW-1:0]      wr_ptr_q;
	logic [PW-1:0]      rd_ptr_q;
	logic [PW:0]        count_q;
	logic               push;
	logic               pop;
	logic [3:0]         shamt;
	bsc_pkg::bsc_item_t aligned;

	// raw pressure right shifted by eight minus oversampling
	assign shamt = 4'd8 - {2'b00, oss};
	assign aligned.ut = sample.raw_temp;
	assign aligned.up = sample.raw_press >> shamt;

	assign sample_stall = (count_q == (PW+1)'(bsc_pkg::QUEUE_DEPTH));
	assign push = sample_valid && !sample_stall;
	assign item_valid = (count_q != '0);
	assign pop = item_pop && item_valid;
	assign item = entry_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= aligned;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== sv/bsc_back.sv =====
// ----------------------------------------------------------------------------
// bsc_back
// Compensation pipeline: temperature product, 32-stage signed divider,
// pressure polynomial, 32-stage unsigned divider and final correction.
// Holds the result in its last stage until the receiver takes it.
// ----------------------------------------------------------------------------
module bsc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  bsc_pkg::bsc_cal_t   cal,
	input  logic                item_valid,
	output logic                item_pop,
	input  bsc_pkg::bsc_item_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output bsc_pkg::bsc_out_t   result
);

	localparam int S_MUL_T   = 0;
	localparam int S_DEN     = 1;
	localparam int DIV1_LO   = 2;
	localparam int DIV1_HI   = 33;
	localparam int S_TEMP    = 34;
	localparam int S_MUL_B6  = 35;
	localparam int S_MUL_SQ  = 36;
	localparam int S_B3      = 37;
	localparam int S_B4      = 38;
	localparam int S_B7      = 39;
	localparam int S_PDIV    = 40;
	localparam int DIV2_LO   = 41;
	localparam int DIV2_HI   = 72;
	localparam int S_PMUL    = 73;
	localparam int S_PMUL2   = 74;
	localparam int S_PSUM    = 75;
	localparam int NST       = 76;

	bsc_pkg::bsc_ctx_t pipe_q [NST];
	logic              vld_q  [NST];
	bsc_pkg::bsc_ctx_t nxt    [NST];
	bsc_pkg::bsc_ctx_t head;
	logic              en;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] absv(input logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	// arithmetic right shift of a 32-bit word, kept apart from unsigned sums
	function automatic logic [31:0] asr(input logic [31:0] v, input int n);
		return $signed(v) >>> n;
	endfunction

	// one stage of work, chosen by stage position
	function automatic bsc_pkg::bsc_ctx_t stage_fn(input int idx, input bsc_pkg::bsc_ctx_t c,
			input bsc_pkg::bsc_cal_t k);
		bsc_pkg::bsc_ctx_t r;
		logic [32:0] r2;
		logic [31:0] v;
		logic [31:0] w;
		logic [31:0] u;
		logic [31:0] p;
		r = c;
		r2 = '0;
		v = '0;
		w = '0;
		u = '0;
		p = '0;
		if ((idx >= DIV1_LO && idx <= DIV1_HI) || (idx >= DIV2_LO && idx <= DIV2_HI)) begin
			// restoring divide, one quotient bit per stage
			r2 = {c.rem, c.num[31]};
			if (r2 >= {1'b0, c.den}) begin
				r.rem = 32'(r2 - {1'b0, c.den});
				r.quo = {c.quo[30:0], 1'b1};
			end else begin
				r.rem = r2[31:0];
				r.quo = {c.quo[30:0], 1'b0};
			end
			r.num = {c.num[30:0], 1'b0};
		end else begin
			case (idx)
				S_MUL_T: begin
					r.t0 = ({16'd0, c.ut} - {16'd0, k.ac6}) * {16'd0, k.ac5};
				end
				S_DEN: begin
					r.x1 = $signed(c.t0) >>> 15;
					v = r.x1 + sx16(k.md);
					w = sx16(k.mc) << 11;
					r.dz = (v == '0);
					r.neg = v[31] ^ w[31];
					r.num = absv(w);
					r.den = absv(v);
					r.rem = '0;
					r.quo = '0;
				end
				S_TEMP: begin
					v = c.neg ? (~c.quo + 32'd1) : c.quo;
					w = c.x1 + v;
					u = $signed(w + 32'd8) >>> 4;
					r.temp = u[15:0];
					r.b5 = w - 32'd4000;
				end
				S_MUL_B6: begin
					r.t0 = c.b5 * c.b5;
					r.t1 = sx16(k.ac2) * c.b5;
					r.t2 = sx16(k.ac3) * c.b5;
				end
				S_MUL_SQ: begin
					v = $signed(c.t0) >>> 12;
					r.t0 = sx16(k.b2) * v;
					r.x1 = sx16(k.b1) * v;
				end
				S_B3: begin
					// truncating division by four of the rounded term
					v = ($signed(c.t0) >>> 11) + ($signed(c.t1) >>> 11);
					w = (((sx16(k.ac1) << 2) + v) << k.oss) + 32'd2;
					w = w + (w[31] ? 32'd3 : 32'd0);
					r.b3 = $signed(w) >>> 2;
					u = asr(c.t2, 13) + asr(c.x1, 16) + 32'd2;
					r.t0 = $signed(u) >>> 2;
				end
				S_B4: begin
					v = {16'd0, k.ac4} * (c.t0 + 32'd32768);
					r.den = v >> 15;
					r.dz = c.dz || (r.den == '0);
				end
				S_B7: begin
					r.t0 = ({8'd0, c.up} - c.b3) * (32'd50000 >> k.oss);
				end
				S_PDIV: begin
					r.dbl = c.t0[31];
					r.num = c.t0[31] ? c.t0 : {c.t0[30:0], 1'b0};
					r.rem = '0;
					r.quo = '0;
				end
				S_PMUL: begin
					p = c.dbl ? {c.quo[30:0], 1'b0} : c.quo;
					r.x1 = p;
					v = $signed(p) >>> 8;
					r.t0 = v * v;
					r.t1 = 32'd7357 * p;
				end
				S_PMUL2: begin
					r.t0 = c.t0 * 32'd3038;
					r.t1 = $signed(32'd0 - c.t1) >>> 16;
				end
				S_PSUM: begin
					v = asr(c.t0, 16) + c.t1 + 32'd3791;
					r.t0 = c.x1 + asr(v, 4);
				end
				default: begin
					r = c;
				end
			endcase
		end
		return r;
	endfunction

	// pipeline advances unless the finished result is held
	assign en = !(vld_q[NST-1] && result_stall);
	assign item_pop = en;

	always_comb begin
		head = '0;
		head.ut = item.ut;
		head.up = item.up;
	end

	// next value of every stage
	always_comb begin
		for (int i = 0; i < NST; i++) begin
			nxt[i] = stage_fn(i, (i == 0) ? head : pipe_q[(i == 0) ? 0 : i-1], cal);
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NST; i++) begin
				pipe_q[i] <= nxt[i];
			end
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NST; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (en) begin
			vld_q[0] <= item_valid;
			for (int i = 1; i < NST; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// result fields, zero when a divisor was zero
	assign result_valid = vld_q[NST-1];
	assign result.temperature = pipe_q[NST-1].dz ? 16'sd0 : $signed(pipe_q[NST-1].temp);
	assign result.pressure = pipe_q[NST-1].dz ? 32'sd0 : $signed(pipe_q[NST-1].t0);
	assign result.div_zero = pipe_q[NST-1].dz;

endmodule

// ===== sv/barometric_sensor_compensation.sv =====
// ----------------------------------------------------------------------------
// barometric_sensor_compensation
// Integer temperature and pressure compensation for a barometric sensor.
// ----------------------------------------------------------------------------
// Usage:
//   The sample channel (sample_valid / sample_stall / sample) carries one raw
//   temperature word and one raw 24-bit pressure reading per transfer. The
//   result channel (result_valid / result_stall / result) returns temperature
//   in 0.1 degC, pressure in Pa and a divide-by-zero flag, one per sample, in
//   order. Calibration and oversampling are written over the cfg port
//   (cfg_valid / cfg_ready / cfg_index / cfg_data) while no sample is in
//   flight; cfg_ready is always high and indexes above five are ignored.
//   A sample waits in the input queue, then passes down the 76-stage
//   pipeline, of which two 32-stage dividers (one quotient bit per
//   stage) make up most. Throughput is one sample per cycle while the
//   receiver does not stall. When the receiver stalls a valid result,
//   the whole pipeline holds; the four-entry input queue keeps taking
//   samples until it fills, then sample_stall rises.
//   Reset clears all coefficients to zero and empties queue and pipeline.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  bsc_pkg::bsc_in_t   sample,
	output logic               result_valid,
	input  logic               result_stall,
	output bsc_pkg::bsc_out_t  result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	logic [31:0]        ac1_ac2_q;
	logic [31:0]        ac3_ac4_q;
	logic [31:0]        ac5_ac6_q;
	logic [31:0]        b1_b2_q;
	logic [31:0]        mc_md_q;
	logic [1:0]         oss_q;
	bsc_pkg::bsc_cal_t  cal;
	logic               item_valid;
	logic               item_pop;
	bsc_pkg::bsc_item_t item;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac1_ac2_q <= '0;
			ac3_ac4_q <= '0;
			ac5_ac6_q <= '0;
			b1_b2_q   <= '0;
			mc_md_q   <= '0;
			oss_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bsc_pkg::REG_AC1_AC2: ac1_ac2_q <= cfg_data;
				bsc_pkg::REG_AC3_AC4: ac3_ac4_q <= cfg_data;
				bsc_pkg::REG_AC5_AC6: ac5_ac6_q <= cfg_data;
				bsc_pkg::REG_B1_B2:   b1_b2_q   <= cfg_data;
				bsc_pkg::REG_MC_MD:   mc_md_q   <= cfg_data;
				bsc_pkg::REG_OSS:     oss_q     <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// coefficient fields
	assign cal.ac1 = ac1_ac2_q[15:0];
	assign cal.ac2 = ac1_ac2_q[31:16];
	assign cal.ac3 = ac3_ac4_q[15:0];
	assign cal.ac4 = ac3_ac4_q[31:16];
	assign cal.ac5 = ac5_ac6_q[15:0];
	assign cal.ac6 = ac5_ac6_q[31:16];
	assign cal.b1  = b1_b2_q[15:0];
	assign cal.b2  = b1_b2_q[31:16];
	assign cal.mc  = mc_md_q[15:0];
	assign cal.md  = mc_md_q[31:16];
	assign cal.oss = oss_q;

	bsc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.oss          (oss_q),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.item_valid   (item_valid),
		.item_pop     (item_pop),
		.item         (item)
	);

	bsc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cal          (cal),
		.item_valid   (item_valid),
		.item_pop     (item_pop),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ===== tb/sv/tb_barometric_sensor_compensation.sv =====
// ----------------------------------------------------------------------------
// tb_barometric_sensor_compensation
// Self-checking bench for the barometric compensation pipeline: a local
// integer predictor computes each expected temperature/pressure pair at the
// sample transfer and the checker compares results in order, under varied
// calibration sets, oversampling settings and random idle/stall pressure.
// ----------------------------------------------------------------------------
module tb_barometric_sensor_compensation;

	localparam logic [2:0] REG_UNUSED_LO = 3'd6;
	localparam logic [2:0] REG_UNUSED_HI = 3'd7;
	localparam int DRAIN_CYCLES  = 90;
	localparam int WATCHDOG_MAX  = 20000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              sample_valid = 1'b0;
	logic              sample_stall;
	bsc_pkg::bsc_in_t  sample = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	bsc_pkg::bsc_out_t result;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [2:0]        cfg_index = '0;
	logic [31:0]       cfg_data = '0;

	// Local copy of calibration registers
	logic [31:0]       cal_regs [6];
	bsc_pkg::bsc_out_t pending_results [$];
	int                gap_pct = 0;
	int                stall_pct = 0;
	int                errors = 0;
	int                samples_sent = 0;
	int                results_seen = 0;
	int                div_zero_seen = 0;
	int                idle_cycles = 0;

	barometric_sensor_compensation i_dut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------- predictor ----------------
	function automatic logic [31:0] sx16(logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] asr(logic [31:0] v, int n);
		return $signed(v) >>> n;
	endfunction

	function automatic logic [31:0] sdiv(logic [31:0] a, logic [31:0] b);
		longint q;
		q = longint'($signed(a)) / longint'($signed(b));
		return q[31:0];
	endfunction

	function automatic bsc_pkg::bsc_out_t compensate(bsc_pkg::bsc_in_t s);
		logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
		logic [31:0] ut, up, x1, x2, x3, b5, b6, b3, b4, b7, p, sq, den, temp;
		int oss;
		bsc_pkg::bsc_out_t r;
		ac1 = sx16(cal_regs[bsc_pkg::REG_AC1_AC2][15:0]);
		ac2 = sx16(cal_regs[bsc_pkg::REG_AC1_AC2][31:16]);
		ac3 = sx16(cal_regs[bsc_pkg::REG_AC3_AC4][15:0]);
		ac4 = {16'd0, cal_regs[bsc_pkg::REG_AC3_AC4][31:16]};
		ac5 = {16'd0, cal_regs[bsc_pkg::REG_AC5_AC6][15:0]};
		ac6 = {16'd0, cal_regs[bsc_pkg::REG_AC5_AC6][31:16]};
		b1  = sx16(cal_regs[bsc_pkg::REG_B1_B2][15:0]);
		b2  = sx16(cal_regs[bsc_pkg::REG_B1_B2][31:16]);
		mc  = sx16(cal_regs[bsc_pkg::REG_MC_MD][15:0]);
		md  = sx16(cal_regs[bsc_pkg::REG_MC_MD][31:16]);
		oss = cal_regs[bsc_pkg::REG_OSS][1:0];
		ut  = {16'd0, s.raw_temp};
		up  = {8'd0, s.raw_press} >> (8 - oss);
		r   = '0;
		r.div_zero = 1'b1;

		// temperature
		x1  = asr((ut - ac6) * ac5, 15);
		den = x1 + md;
		if (den == 0)
			return r;
		x2   = sdiv(mc << 11, den);
		b5   = x1 + x2;
		temp = asr(b5 + 32'd8, 4);

		// pressure
		b6 = b5 - 32'd4000;
		sq = asr(b6 * b6, 12);
		x1 = asr(b2 * sq, 11);
		x2 = asr(ac2 * b6, 11);
		x3 = x1 + x2;
		b3 = sdiv(((ac1 * 32'd4 + x3) << oss) + 32'd2, 32'd4);
		x1 = asr(ac3 * b6, 13);
		x2 = asr(b1 * sq, 16);
		x3 = asr(x1 + x2 + 32'd2, 2);
		b4 = (ac4 * (x3 + 32'd32768)) >> 15;
		if (b4 == 0)
			return r;
		b7 = (up - b3) * (32'd50000 >> oss);
		if (b7 < 32'h8000_0000)
			p = (b7 * 32'd2) / b4;
		else
			p = (b7 / b4) * 32'd2;
		x1 = asr(p, 8) * asr(p, 8);
		x1 = asr(x1 * 32'd3038, 16);
		x2 = asr(32'd0 - 32'd7357 * p, 16);
		p  = p + asr(x1 + x2 + 32'd3791, 4);

		r.temperature = temp[15:0];
		r.pressure    = p;
		r.div_zero    = 1'b0;
		return r;
	endfunction

	// ---------------- result side ----------------
	// receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_stall <= 1'b0;
		else
			result_stall <= ($urandom_range(99) < stall_pct);
	end

	// in-order result check and watchdog
	always @(posedge clk) begin
		bsc_pkg::bsc_out_t want;
		if (arst_n) begin
			if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_MAX) begin
				$display("watchdog: no transfer for %0d cycles", WATCHDOG_MAX);
				$display("Regression FAIL");
				$finish;
			end
			if (result_valid && !result_stall) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					$error("unexpected result transfer: %p", result);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (want.div_zero)
						div_zero_seen++;
					if (result.temperature !== want.temperature) begin
						$error("temperature exp %0d got %0d", want.temperature,
							result.temperature);
						errors++;
					end
					if (result.pressure !== want.pressure) begin
						$error("pressure exp %0d got %0d", want.pressure, result.pressure);
						errors++;
					end
					if (result.div_zero !== want.div_zero) begin
						$error("div_zero exp %0b got %0b", want.div_zero, result.div_zero);
						errors++;
					end
				end
			end
		end
	end

	// ---------------- driver tasks ----------------
	task automatic send_sample(logic [15:0] t, logic [23:0] pr);
		bsc_pkg::bsc_in_t s;
		s.raw_temp  = t;
		s.raw_press = pr;
		if ($urandom_range(99) < gap_pct) begin
			sample_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		do @(posedge clk); while (sample_stall);
		pending_results.push_back(compensate(s));
		samples_sent++;
	endtask

	// stop sending and let every outstanding result come back
	task automatic drain_results(int extra);
		sample_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// register write; valid is lowered by the caller once the burst is done
	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			bsc_pkg::REG_OSS:             cal_regs[idx] = {30'd0, data[1:0]};
			REG_UNUSED_LO, REG_UNUSED_HI: ;
			default:                      cal_regs[idx] = data;
		endcase
	endtask

	task automatic load_calibration(logic [31:0] a12, logic [31:0] a34, logic [31:0] a56,
			logic [31:0] bb, logic [31:0] mm, logic [1:0] oss);
		drain_results(DRAIN_CYCLES);
		write_reg(bsc_pkg::REG_AC1_AC2, a12);
		write_reg(bsc_pkg::REG_AC3_AC4, a34);
		write_reg(bsc_pkg::REG_AC5_AC6, a56);
		write_reg(bsc_pkg::REG_B1_B2, bb);
		write_reg(bsc_pkg::REG_MC_MD, mm);
		write_reg(bsc_pkg::REG_OSS, {30'd0, oss});
		cfg_valid <= 1'b0;
	endtask

	// typical factory calibration
	task automatic load_typical(logic [1:0] oss);
		load_calibration({-16'sd72, 16'sd408}, {16'd32741, -16'sd14383},
			{16'd23153, 16'd32757}, {16'sd4, 16'sd6190}, {16'sd2868, -16'sd8711}, oss);
	endtask

	// ---------------- tests ----------------
	// all coefficients zero after reset: temperature divisor is zero
	task automatic test_reset_defaults();
		send_sample(16'd27898, 24'h5D2300);
		send_sample(16'hFFFF, 24'hFFFFFF);
	endtask

	// typical calibration, field extremes at both ends of oversampling, one sample at each middle setting
	task automatic test_typical_extremes();
		logic [1:0] oss;
		for (int k = 0; k < 2; k++) begin
			oss = k ? 2'd3 : 2'd0;
			load_typical(oss);
			send_sample(16'd27898, 24'(23843) << (8 - oss));
			send_sample(16'd0, 24'd0);
			send_sample(16'hFFFF, 24'hFFFFFF);
			send_sample(16'h0000, 24'hFFFFFF);
			send_sample(16'hFFFF, 24'h000000);
		end
		load_typical(2'd1);
		send_sample(16'd27898, 24'h5D2300);
		load_typical(2'd2);
		send_sample(16'd27898, 24'h5D2300);
	endtask

	// each divisor zero on its own
	task automatic test_zero_divisors();
		// ac5 = 0 and md = 0 give a zero temperature divisor
		load_calibration({-16'sd72, 16'sd408}, {16'd32741, -16'sd14383},
			{16'd23153, 16'd0}, {16'sd4, 16'sd6190}, {16'sd0, -16'sd8711}, 2'd0);
		send_sample(16'd27898, 24'h5D2300);
		// ac4 = 0 gives a zero pressure divisor
		load_calibration({-16'sd72, 16'sd408}, {16'd0, -16'sd14383},
			{16'd23153, 16'd32757}, {16'sd4, 16'sd6190}, {16'sd2868, -16'sd8711}, 2'd2);
		send_sample(16'd27898, 24'h5D2300);
		send_sample(16'd1234, 24'hABCDEF);
	endtask

	// writes to indexes above five change nothing; oversampling masked
	task automatic test_ignored_index();
		load_typical(2'd0);
		write_reg(REG_UNUSED_LO, 32'hFFFF_FFFF);
		write_reg(REG_UNUSED_HI, 32'h0000_0000);
		write_reg(bsc_pkg::REG_OSS, 32'hFFFF_FFFE);
		cfg_valid <= 1'b0;
		send_sample(16'd27898, 24'h5D2300);
		send_sample(16'd30000, 24'h800000);
	endtask

	// random calibration sets, changed every hundred samples
	task automatic test_random(int count, int gap, int stall);
		logic [31:0] r [5];
		gap_pct   = gap;
		stall_pct = stall;
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 0) begin
				case ($urandom_range(3))
					0: load_typical(2'($urandom_range(3)));
					1: begin
						foreach (r[j]) r[j] = $urandom();
						load_calibration(r[0], r[1], r[2], r[3], r[4], 2'($urandom_range(3)));
					end
					2: load_calibration('1, '1, '1, '1, '1, 2'd3);
					default: begin
						// typical set with random jitter
						load_calibration(
							{16'($urandom_range(200)) - 16'd172, 16'd408 + 16'($urandom_range(255))},
							{16'd32000 + 16'($urandom_range(1500)), 16'($urandom())},
							{16'($urandom()), 16'd32000 + 16'($urandom_range(700))},
							{16'($urandom_range(15)), 16'($urandom())},
							{16'd2000 + 16'($urandom_range(2000)), 16'($urandom())},
							2'($urandom_range(3)));
						if ($urandom_range(1))
							write_reg($urandom_range(1) ? REG_UNUSED_LO : REG_UNUSED_HI,
								$urandom());
						cfg_valid <= 1'b0;
					end
				endcase
			end
			if (i == count / 2 + 7)
				drain_results(0);
			send_sample(16'($urandom()), 24'($urandom()));
		end
	endtask

	initial begin
		foreach (cal_regs[j]) cal_regs[j] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_typical_extremes();
		test_zero_divisors();
		test_ignored_index();
		test_random(400, 0, 0);
		test_random(400, 82, 0);
		test_random(400, 0, 82);
		test_random(400, 33, 33);
		drain_results(DRAIN_CYCLES);
		$display("Covered %0d samples, %0d results (%0d divisor-zero) over typical,",
			samples_sent, results_seen, div_zero_seen);
		$display("random and saturated calibration at all oversampling levels; %0d errors",
			errors);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
